// ----- src/srgb_box_mip_downsampler_assert.svh -----
// Assertion macros for the sRGB box mip downsampler.
// Each macro expects clk and rst_n in scope.
`ifndef SRGB_BOX_MIP_DOWNSAMPLER_ASSERT_SVH
`define SRGB_BOX_MIP_DOWNSAMPLER_ASSERT_SVH

// same-cycle implication
`define SBMD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbmd: assertion failed");

// next-cycle implication
`define SBMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbmd: assertion failed");

`endif

// ----- src/sbmd_pkg.sv -----
// ---------------------------------------------------------------------------
// sbmd_pkg
// Types, constants and curve tables of the sRGB box mip downsampler.
// ---------------------------------------------------------------------------
package sbmd_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_LINEAR_BITS = 12;
  localparam int HEIGHT_LIMIT    = 4096;
  localparam int HEIGHT_BITS     = 13;
  localparam int ROW_BITS        = 12;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int QUEUE_DEPTH     = 4;
  localparam int TAB_BITS        = 18;
  localparam int SEARCH_STEPS    = 8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SRGB_MODE     = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       level_done;
  } pix_out_t;

  // control word riding along with each queued group sum
  typedef struct packed {
    logic [1:0] shift;   // log2 of the number of pixels summed
    logic       srgb;
    logic       done;
  } qctl_t;

  typedef logic [TAB_BITS-1:0] tab_t [256];

  // truncated Q30 fifth power
  function automatic logic [63:0] sbmd_pow5(input logic [63:0] r);
    logic [63:0] p;
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  // sRGB-to-linear in Q30 at half-code h (c = h/510)
  function automatic logic [63:0] sbmd_lin_q30(input int unsigned h);
    logic [63:0] t;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] c;
    if (h <= 20) begin
      return ((64'(h) * 64'd100 << 30) + 64'd329460) / 64'd658920;
    end
    t = ((64'(1000 * h + 28050) << 30) + 64'd269025) / 64'd538050;
    if (t >= (64'd1 << 30)) begin
      return 64'd1 << 30;
    end
    x2 = (t * t) >> 30;
    r  = '0;
    for (int b = 29; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (sbmd_pow5(c) <= x2) begin
        r = c;
      end
    end
    return (x2 * r) >> 30;
  endfunction

  // byte -> unsigned 0.lb linear value
  function automatic tab_t sbmd_dec_tab(input int lb);
    tab_t        tab;
    logic [63:0] m;
    m = (64'd1 << lb) - 64'd1;
    for (int i = 0; i < 256; i++) begin
      tab[i] = TAB_BITS'((sbmd_lin_q30(2 * i) * m + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

  // encode thresholds on a sum scaled to four pixels:
  // byte b is reached when 4/n * sum >= ceil(L(2b-1) * M / 2^28)
  function automatic tab_t sbmd_thr_tab(input int lb);
    tab_t        tab;
    logic [63:0] m;
    m = (64'd1 << lb) - 64'd1;
    tab[0] = '0;
    for (int i = 1; i < 256; i++) begin
      tab[i] = TAB_BITS'((sbmd_lin_q30(2 * i - 1) * m + (64'd1 << 28) - 64'd1) >> 28);
    end
    return tab;
  endfunction

endpackage

// ----- src/sbmd_stream_if.sv -----
// ---------------------------------------------------------------------------
// sbmd_stream_if
// Valid/ready stream channel carrying one item of type T.
// ---------------------------------------------------------------------------
interface sbmd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/sbmd_ram.sv -----
// ---------------------------------------------------------------------------
// sbmd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sbmd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sbmd_queue.sv -----
// ---------------------------------------------------------------------------
// sbmd_queue
// Short register FIFO between the front and back parts.
// ---------------------------------------------------------------------------
module sbmd_queue import sbmd_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [W-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- src/sbmd_front.sv -----
// ---------------------------------------------------------------------------
// sbmd_front
// Accepts source pixels, tracks raster position, forms 2x2 group sums
// through the row store and pushes finished groups to the queue.
// ---------------------------------------------------------------------------
module sbmd_front import sbmd_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int LINEAR_BITS = DEF_LINEAR_BITS,
  parameter int QW          = 4 * (LINEAR_BITS + 2) + $bits(qctl_t)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                      in_valid,
  input  pix_in_t                   in_data,
  output logic                      in_ready,
  output logic                      q_push,
  output logic [QW-1:0]             q_wdata,
  input  logic                      q_full
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SD = MAX_WIDTH / 2;
  localparam int AW = (SD > 1) ? $clog2(SD) : 1;
  localparam int PW = LINEAR_BITS;
  localparam int GW = PW + 1;
  localparam int SW = PW + 2;
  localparam tab_t DEC_TAB = sbmd_dec_tab(LINEAR_BITS);

  logic [WW-1:0]          w_r;
  logic [HEIGHT_BITS-1:0] h_r;
  logic                   srgb_r;
  logic [CW-1:0]          col_r;
  logic [ROW_BITS-1:0]    row_r;
  logic [GW-1:0]          pair_r [4];

  logic [7:0]    bval [4];
  logic [PW-1:0] pix  [4];
  logic [GW-1:0] grp  [4];
  logic [SW-1:0] sum  [4];
  logic [4*GW-1:0] ram_wdata, ram_rdata;

  logic acc, keep, w_one, h_one, col_keep, row_keep;
  logic col_last, row_last, oc_last, oy_last;
  logic gready, emit, pair_we, ram_we, ram_re, cfg_hit;
  logic [WW-1:0]          col_w;
  logic [HEIGHT_BITS-1:0] row_w;
  logic [WW-1:0]          w_cfg;
  logic [HEIGHT_BITS-1:0] h_cfg;
  qctl_t ctl;

  assign bval[0] = in_data.red_in;
  assign bval[1] = in_data.green_in;
  assign bval[2] = in_data.blue_in;
  assign bval[3] = in_data.alpha_in;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (srgb_r && c < 3) begin
        pix[c] = DEC_TAB[bval[c]][PW-1:0];
      end else begin
        pix[c] = PW'(bval[c]);
      end
    end
  end

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  assign col_w    = WW'(col_r);
  assign row_w    = HEIGHT_BITS'(row_r);
  assign w_one    = (w_r == WW'(1));
  assign h_one    = (h_r == HEIGHT_BITS'(1));
  // odd last column / row of a larger source is dropped
  assign col_keep = w_one || (col_w < (w_r & ~WW'(1)));
  assign row_keep = h_one || (row_w < (h_r & ~HEIGHT_BITS'(1)));
  assign keep     = col_keep && row_keep;
  assign col_last = (col_w == w_r - WW'(1));
  assign row_last = (row_w == h_r - HEIGHT_BITS'(1));
  assign oc_last  = w_one || ((col_w >> 1) == (w_r >> 1) - WW'(1));
  assign oy_last  = h_one || ((row_w >> 1) == (h_r >> 1) - HEIGHT_BITS'(1));

  always_comb begin
    gready = 1'b0;
    emit   = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    for (int c = 0; c < 4; c++) begin
      grp[c] = GW'(pix[c]);
      sum[c] = '0;
    end
    if (w_one) begin
      gready = 1'b1;
    end else if (!col_r[0]) begin
      // fetch the stored upper-row sum ahead of the odd column
      ram_re = !h_one && row_r[0];
    end else begin
      gready = 1'b1;
      for (int c = 0; c < 4; c++) begin
        grp[c] = pair_r[c] + GW'(pix[c]);
      end
    end
    if (gready) begin
      if (h_one) begin
        emit = 1'b1;
        for (int c = 0; c < 4; c++) begin
          sum[c] = SW'(grp[c]);
        end
      end else if (!row_r[0]) begin
        ram_we = !w_one;
      end else begin
        emit = 1'b1;
        for (int c = 0; c < 4; c++) begin
          if (w_one) begin
            sum[c] = SW'(pair_r[c]) + SW'(grp[c]);
          end else begin
            sum[c] = SW'(ram_rdata[c*GW +: GW]) + SW'(grp[c]);
          end
        end
      end
    end
  end

  // pair holds the even-column pixel, or for a one-wide source the even-row pixel
  assign pair_we = acc && keep &&
                   ((!w_one && !col_r[0]) || (w_one && !h_one && !row_r[0]));

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ram_wdata[c*GW +: GW] = grp[c];
    end
  end

  sbmd_ram #(
    .W     (4 * GW),
    .DEPTH (SD),
    .AW    (AW)
  ) u_row_store (
    .clk   (clk),
    .we    (acc && keep && ram_we),
    .waddr (AW'(col_r >> 1)),
    .wdata (ram_wdata),
    .re    (acc && keep && ram_re),
    .raddr (AW'(col_r >> 1)),
    .rdata (ram_rdata)
  );

  assign ctl.shift = {1'b0, !w_one} + {1'b0, !h_one};
  assign ctl.srgb  = srgb_r;
  assign ctl.done  = oc_last && oy_last;
  assign q_push    = acc && keep && emit;
  assign q_wdata   = {sum[3], sum[2], sum[1], sum[0], ctl};

  // zero reads as one, oversize saturates
  always_comb begin
    if (cfg_wdata == '0) begin
      w_cfg = WW'(1);
    end else if (32'(cfg_wdata) > MAX_WIDTH) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = WW'(cfg_wdata);
    end
    if (cfg_wdata == '0) begin
      h_cfg = HEIGHT_BITS'(1);
    end else if (32'(cfg_wdata) > HEIGHT_LIMIT) begin
      h_cfg = HEIGHT_BITS'(HEIGHT_LIMIT);
    end else begin
      h_cfg = HEIGHT_BITS'(cfg_wdata);
    end
  end

  assign cfg_hit = cfg_we && (cfg_index == CFG_SOURCE_WIDTH ||
                              cfg_index == CFG_SOURCE_HEIGHT ||
                              cfg_index == CFG_SRGB_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WW'(1);
      h_r    <= HEIGHT_BITS'(1);
      srgb_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_WIDTH:  w_r    <= w_cfg;
          CFG_SOURCE_HEIGHT: h_r    <= h_cfg;
          CFG_SRGB_MODE:     srgb_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        col_r <= '0;
        row_r <= '0;
      end else if (acc) begin
        if (col_last) begin
          col_r <= '0;
          row_r <= row_last ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      for (int c = 0; c < 4; c++) begin
        pair_r[c] <= GW'(pix[c]);
      end
    end
  end

endmodule

// ----- src/sbmd_back.sv -----
// ---------------------------------------------------------------------------
// sbmd_back
// Turns queued group sums into output bytes: rounded averages, or an
// eight-stage binary search of the sRGB encode thresholds.
// ---------------------------------------------------------------------------
module sbmd_back import sbmd_pkg::*; #(
  parameter int LINEAR_BITS = DEF_LINEAR_BITS,
  parameter int QW          = 4 * (LINEAR_BITS + 2) + $bits(qctl_t)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [QW-1:0] q_rdata,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  output pix_out_t      out_data,
  input  logic          out_ready
);

  localparam int SW  = LINEAR_BITS + 2;
  localparam int CTW = $bits(qctl_t);
  localparam int NST = SEARCH_STEPS + 1;
  localparam int LST = NST - 1;
  localparam tab_t THR_TAB = sbmd_thr_tab(LINEAR_BITS);

  logic          vld_r   [NST];
  logic [SW-1:0] snorm_r [NST][3];
  logic [7:0]    code_r  [NST][3];
  logic [7:0]    alpha_r [NST];
  logic          srgb_r  [NST];
  logic          done_r  [NST];

  logic [SW-1:0] snorm0 [3];
  logic [7:0]    code0  [3];
  logic [7:0]    avg    [4];
  logic [SW-1:0] qsum   [4];
  logic [7:0]    code_nxt [NST][3];
  logic [7:0]    cand;
  qctl_t         qc;
  logic          en;

  assign en    = !vld_r[LST] || out_ready;
  assign q_pop = en && !q_empty;
  assign qc    = q_rdata[CTW-1:0];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qsum[c] = q_rdata[CTW + c*SW +: SW];
      // half of n equals the shift for n of 1, 2 or 4
      avg[c]  = 8'(((SW+1)'(qsum[c]) + (SW+1)'(qc.shift)) >> qc.shift);
    end
    for (int c = 0; c < 3; c++) begin
      snorm0[c] = qc.srgb ? SW'(qsum[c] << (2'd2 - qc.shift)) : '0;
      code0[c]  = qc.srgb ? 8'd0 : avg[c];
    end
  end

  // one result bit per stage, MSB first
  always_comb begin
    cand = '0;
    for (int j = 0; j < NST; j++) begin
      for (int c = 0; c < 3; c++) begin
        code_nxt[j][c] = code_r[j][c];
      end
    end
    for (int j = 1; j < NST; j++) begin
      for (int c = 0; c < 3; c++) begin
        cand = code_r[j-1][c] | 8'(1 << (SEARCH_STEPS - j));
        if (srgb_r[j-1] && (snorm_r[j-1][c] >= THR_TAB[cand][SW-1:0])) begin
          code_nxt[j][c] = cand;
        end else begin
          code_nxt[j][c] = code_r[j-1][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= !q_empty;
      for (int j = 1; j < NST; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        snorm_r[0][c] <= snorm0[c];
        code_r[0][c]  <= code0[c];
      end
      alpha_r[0] <= avg[3];
      srgb_r[0]  <= qc.srgb;
      done_r[0]  <= qc.done;
      for (int j = 1; j < NST; j++) begin
        for (int c = 0; c < 3; c++) begin
          snorm_r[j][c] <= snorm_r[j-1][c];
          code_r[j][c]  <= code_nxt[j][c];
        end
        alpha_r[j] <= alpha_r[j-1];
        srgb_r[j]  <= srgb_r[j-1];
        done_r[j]  <= done_r[j-1];
      end
    end
  end

  assign out_valid           = vld_r[LST];
  assign out_data.red_out    = code_r[LST][0];
  assign out_data.green_out  = code_r[LST][1];
  assign out_data.blue_out   = code_r[LST][2];
  assign out_data.alpha_out  = alpha_r[LST];
  assign out_data.level_done = done_r[LST];

endmodule

// ----- src/srgb_box_mip_downsampler.sv -----
// Path: a pixel that completes a 2x2 group is queued, then passes the back
// part's input register and 8-stage encode search to out_ch; stalls hold it.
// Throughput: one source pixel per cycle while the queue is not full; the row
// store's one read and one write port and the encode search keep that pace.
// Reset (synchronous, rst_n low): position counters, queue and output clear;
// config returns to width 1, height 1, linear mode. Row store is not cleared.
// ---------------------------------------------------------------------------
// srgb_box_mip_downsampler
// 2x2 box filter that builds the next mip level, linear or sRGB-correct.
// ---------------------------------------------------------------------------
module srgb_box_mip_downsampler import sbmd_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int LINEAR_BITS = DEF_LINEAR_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  sbmd_stream_if.sink               in_ch,
  sbmd_stream_if.source             out_ch
);

  localparam int QW = 4 * (LINEAR_BITS + 2) + $bits(qctl_t);

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  sbmd_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .LINEAR_BITS (LINEAR_BITS),
    .QW          (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_data   (in_ch.data),
    .in_ready  (in_ch.ready),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  sbmd_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sbmd_back #(
    .LINEAR_BITS (LINEAR_BITS),
    .QW          (QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .out_ready (out_ch.ready)
  );

endmodule

// ----- src/sbmd_checker.sv -----
// ---------------------------------------------------------------------------
// sbmd_checker
// Port-level checks of the mip downsampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "srgb_box_mip_downsampler_assert.svh"

module sbmd_checker import sbmd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pix_out_t out_data
);

  // a stalled result stays offered and unchanged
  `SBMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // an empty output lets the back part drain the queue, so input opens up
  `SBMD_ASSERT_NEXT(a_drain_ready, !out_valid, in_ready)

  // leaving reset: nothing offered, ready for input
  `SBMD_ASSERT_SAME(a_reset_idle, $rose(rst_n), !out_valid && in_ready)

endmodule

bind srgb_box_mip_downsampler sbmd_checker u_sbmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- tb/srgb_box_mip_downsampler_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srgb_box_mip_downsampler_checker
// Passive scoreboard. It follows the register writes and every accepted source
// pixel, runs its own box-filter model of the mip level and queues the
// pixels due on the output. Each accepted output pixel is compared with the
// oldest queued one, field by field.
// ---------------------------------------------------------------------------
module srgb_box_mip_downsampler_checker import sbmd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  pix_in_t                   in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  pix_out_t                  out_data,
  output int unsigned               fail_count,
  output int unsigned               pending_count
);

  localparam int unsigned STORE_ENTRIES = DEF_MAX_WIDTH / 2;
  localparam longint unsigned LIN_MAX = (64'd1 << DEF_LINEAR_BITS) - 64'd1;

  typedef logic [3:0][15:0] chan_sums_t;  // index 0 red .. 3 alpha

  logic [DEF_LINEAR_BITS-1:0] decode_lut [256];
  longint unsigned            knee_q30   [256];

  logic [CFG_DATA_BITS-1:0] src_w;
  logic [CFG_DATA_BITS-1:0] src_h;
  logic                     srgb_on;

  chan_sums_t  row_sums [STORE_ENTRIES];
  chan_sums_t  pair_sums;
  int unsigned col_pos;
  int unsigned row_pos;
  pix_out_t    expected_pixels [$];

  // truncated fifth power, Q30
  function automatic longint unsigned fifth_pow(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  // sRGB curve to linear light, Q30, at half-code h (h / 510)
  function automatic longint unsigned curve_q30(input int unsigned h);
    longint unsigned hh;
    longint unsigned t;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    hh = h;
    if (h <= 20) begin
      return (((hh * 100) << 30) + 64'd329460) / 64'd658920;
    end
    t = ((((hh * 1000) + 64'd28050) << 30) + 64'd269025) / 64'd538050;
    if (t >= (64'd1 << 30)) begin
      return 64'd1 << 30;
    end
    sq = (t * t) >> 30;
    // largest root whose fifth power does not exceed t^2: gives t^2.4 below
    root = '0;
    for (int b = 29; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (fifth_pow(trial) <= sq) begin
        root = trial;
      end
    end
    return (sq * root) >> 30;
  endfunction

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_BITS-1:0] v,
                                            input int unsigned limit);
    if (v == 0) begin
      return 1;
    end
    return (v > limit) ? limit : int'(v);
  endfunction

  // nearest sRGB byte for a sum of n linear values, ties up
  function automatic logic [7:0] to_srgb(input int unsigned total, input int unsigned n);
    longint unsigned lhs;
    int unsigned     hits;
    lhs = total;
    lhs = lhs << 30;
    hits = 0;
    for (int b = 1; b < 256; b++) begin
      if (lhs >= knee_q30[b] * LIN_MAX * n) begin
        hits++;
      end
    end
    return 8'(hits);
  endfunction

  task automatic restart_level();
    col_pos   = 0;
    row_pos   = 0;
    pair_sums = '0;
  endtask

  task automatic absorb_pixel(input pix_in_t px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     ow;
    int unsigned     oh;
    int unsigned     oc;
    int unsigned     oy;
    int unsigned     n;
    logic [3:0][7:0] raw;
    logic [3:0][7:0] res;
    chan_sums_t      lin;
    chan_sums_t      grp;
    chan_sums_t      tot;
    logic            have_grp;
    logic            emit;
    pix_out_t        want;
    w  = clamp_dim(src_w, DEF_MAX_WIDTH);
    h  = clamp_dim(src_h, HEIGHT_LIMIT);
    ow = (w > 1) ? w / 2 : 1;
    oh = (h > 1) ? h / 2 : 1;
    raw[0] = px.red_in;
    raw[1] = px.green_in;
    raw[2] = px.blue_in;
    raw[3] = px.alpha_in;
    for (int c = 0; c < 4; c++) begin
      lin[c] = (srgb_on && c < 3) ? 16'(decode_lut[raw[c]]) : 16'(raw[c]);
    end
    have_grp = 1'b0;
    emit     = 1'b0;
    grp      = '0;
    tot      = '0;
    // odd last column / row of a dimension above 1 is dropped
    if ((w == 1 || col_pos < 2 * ow) && (h == 1 || row_pos < 2 * oh)) begin
      oc = (w == 1) ? 0 : col_pos >> 1;
      oy = (h == 1) ? row_pos : row_pos >> 1;
      if (w == 1) begin
        grp      = lin;
        have_grp = 1'b1;
      end else if (col_pos % 2 == 0) begin
        pair_sums = lin;
      end else begin
        for (int c = 0; c < 4; c++) begin
          grp[c] = pair_sums[c] + lin[c];
        end
        have_grp = 1'b1;
      end
      if (have_grp) begin
        if (h == 1) begin
          tot  = grp;
          emit = 1'b1;
        end else if (row_pos % 2 == 0) begin
          row_sums[oc] = grp;
        end else begin
          for (int c = 0; c < 4; c++) begin
            tot[c] = row_sums[oc][c] + grp[c];
          end
          emit = 1'b1;
        end
      end
      if (emit) begin
        n = ((w == 1) ? 1 : 2) * ((h == 1) ? 1 : 2);
        for (int c = 0; c < 4; c++) begin
          res[c] = (srgb_on && c < 3) ? to_srgb(tot[c], n) : 8'((tot[c] + n / 2) / n);
        end
        want.red_out    = res[0];
        want.green_out  = res[1];
        want.blue_out   = res[2];
        want.alpha_out  = res[3];
        want.level_done = (oc == ow - 1) && (oy == oh - 1);
        expected_pixels = {expected_pixels, want};
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
      end
    end
  endtask

  task automatic check_pixel(input pix_out_t got);
    pix_out_t want;
    if (expected_pixels.size() == 0) begin
      fail_count <= fail_count + 1;
      $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d done=%0b", $time,
               got.red_out, got.green_out, got.blue_out, got.alpha_out, got.level_done);
    end else begin
      want = expected_pixels.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out ||
          got.level_done !== want.level_done) begin
        fail_count <= fail_count + 1;
        $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d a=%0d done=%0b",
                 $time, want.red_out, want.green_out, want.blue_out, want.alpha_out,
                 want.level_done);
        $display("%0t:                  actual r=%0d g=%0d b=%0d a=%0d done=%0b",
                 $time, got.red_out, got.green_out, got.blue_out, got.alpha_out,
                 got.level_done);
      end
    end
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    for (int i = 0; i < 256; i++) begin
      decode_lut[i] = DEF_LINEAR_BITS'((curve_q30(2 * i) * LIN_MAX + (64'd1 << 29)) >> 30);
      knee_q30[i]   = (i == 0) ? 64'd0 : curve_q30(2 * i - 1);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      src_w   = 1;
      src_h   = 1;
      srgb_on = 1'b0;
      restart_level();
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_WIDTH: begin
            src_w = cfg_wdata;
            restart_level();
          end
          CFG_SOURCE_HEIGHT: begin
            src_h = cfg_wdata;
            restart_level();
          end
          CFG_SRGB_MODE: begin
            srgb_on = cfg_wdata[0];
            restart_level();
          end
          default: ;  // unmapped index: no effect, no restart
        endcase
      end
      if (in_valid && in_ready) begin
        absorb_pixel(in_data);
      end
      if (out_valid && out_ready) begin
        check_pixel(out_data);
      end
    end
    pending_count <= expected_pixels.size();
  end

endmodule

// ----- tb/srgb_box_mip_downsampler_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srgb_box_mip_downsampler_tb
// Streams mip levels of many sizes, linear and sRGB, through the downsampler
// with random gaps and output stalls; the checker beside it scores results.
// ---------------------------------------------------------------------------
module srgb_box_mip_downsampler_tb;
  import sbmd_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

  localparam int unsigned TOTAL_ITEMS  = 1100;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 10_000_000;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  int unsigned hold_requests;
  int unsigned sent_items;
  logic        src_calm;

  sbmd_stream_if #(.T(pix_in_t))  in_if ();
  sbmd_stream_if #(.T(pix_out_t)) out_if ();

  srgb_box_mip_downsampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  srgb_box_mip_downsampler_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_data       (in_if.data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_data      (out_if.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly back to back, short gaps often, long ones rarely
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end
    if (r < 97) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return 8'd0;
    end
    if (r == 1) begin
      return 8'd255;
    end
    return 8'($urandom);
  endfunction

  function automatic pix_in_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a);
    pix_in_t px;
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    px.alpha_in = a;
    return px;
  endfunction

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_BITS-1:0] v);
    if (v == 0) begin
      return 1;
    end
    return (v > 4096) ? 4096 : int'(v);
  endfunction

  task automatic push_pixel(input pix_in_t px);
    int unsigned gap;
    if ($urandom_range(0, 199) == 0) begin
      src_calm = !src_calm;
    end
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= px;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_items++;
  endtask

  // next count pixels of the current level, random content
  task automatic send_pixels(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      push_pixel(make_pixel(random_byte(), random_byte(), random_byte(), random_byte()));
    end
  endtask

  // drop valid and wait until every queued pixel has come out
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_level(input logic [CFG_DATA_BITS-1:0] w,
                               input logic [CFG_DATA_BITS-1:0] h, input logic srgb);
    logic [CFG_DATA_BITS-1:0] mode_word;
    mode_word = {12'($urandom), srgb};  // upper bits are don't-care
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_SRGB_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_spare();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CFG_DATA_BITS'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // output side: random stalls, calm stretches, and long holds on request
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_served;
    logic        sink_calm;
    stall_left   = 0;
    holds_served = 0;
    sink_calm    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) begin
        sink_calm = !sink_calm;
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!sink_calm) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_BITS-1:0] w;
    logic [CFG_DATA_BITS-1:0] h;
    int unsigned              area;
    int unsigned              burst;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SOURCE_WIDTH;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cycle_count   = 0;
    hold_requests = 0;
    sent_items    = 0;
    src_calm      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 linear: full-scale, zero and half-way rounding
    program_level(13'd2, 13'd2, 1'b0);
    push_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    push_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0));
    push_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0));
    push_pixel(make_pixel(8'd0, 8'd255, 8'd1, 8'd254));
    settle();
    // a 2x2 group in sRGB mode
    program_level(13'd2, 13'd2, 1'b1);
    push_pixel(make_pixel(8'd255, 8'd0, 8'd128, 8'd255));
    push_pixel(make_pixel(8'd0, 8'd255, 8'd127, 8'd0));
    push_pixel(make_pixel(8'd255, 8'd255, 8'd1, 8'd1));
    push_pixel(make_pixel(8'd0, 8'd0, 8'd254, 8'd2));
    settle();
    // odd sizes: last row and column dropped
    program_level(13'd3, 13'd3, 1'b1);
    send_pixels(9);
    settle();
    // zero size acts as 1x1; second pixel is the next level
    program_level(13'd0, 13'd0, 1'b0);
    send_pixels(2);
    settle();
    // single row and single column
    program_level(13'd2, 13'd1, 1'b1);
    send_pixels(2);
    settle();
    program_level(13'd1, 13'd3, 1'b0);
    send_pixels(3);
    settle();

    // long output hold while the input keeps offering pixels
    program_level(13'd2, 13'd1, 1'b0);
    hold_requests++;
    send_pixels(160);
    settle();

    // pause mid-level, unmapped write must not restart, then a restarting one
    program_level(13'd4, 13'd4, 1'b1);
    send_pixels(6);
    settle();
    write_spare();
    send_pixels(10);
    send_pixels(5);
    settle();
    program_level(13'd4, 13'd4, 1'b1);
    send_pixels(16);
    settle();

    // largest sizes, width and height saturating; first part of each level
    program_level(13'd8191, 13'd1, 1'b0);
    send_pixels(128);
    settle();
    program_level(13'd4096, 13'd2, 1'b1);
    send_pixels(128);
    settle();
    program_level(13'd1, 13'd8191, 1'b1);
    send_pixels(128);
    settle();

    // random levels; some cut short before the next setting
    while (sent_items < TOTAL_ITEMS) begin
      w = CFG_DATA_BITS'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) :
                                                      $urandom_range(9, 40));
      h = CFG_DATA_BITS'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) :
                                                      $urandom_range(9, 16));
      program_level(w, h, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) begin
        write_spare();
      end
      area = clamp_dim(w) * clamp_dim(h);
      if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, area);
      end else begin
        burst = area * $urandom_range(1, 3);
      end
      if (burst > TOTAL_ITEMS - sent_items) begin
        burst = TOTAL_ITEMS - sent_items;
      end
      send_pixels(burst);
      settle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/sbmd_pkg.sv
src/sbmd_stream_if.sv
src/sbmd_ram.sv
src/sbmd_queue.sv
src/sbmd_front.sv
src/sbmd_back.sv
src/srgb_box_mip_downsampler.sv
src/sbmd_checker.sv
tb/srgb_box_mip_downsampler_checker.sv
tb/srgb_box_mip_downsampler_tb.sv
